[rtl/scg_pkg.sv]
`timescale 1ns / 1ps

package scg_pkg;

  localparam int PIX_W    = 16;
  localparam int LINE_W   = 2 * PIX_W;   // {upper, middle} per column
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W    = 21;          // +-16 * 65535 fits
  localparam int DIV_SHIFT = 11;         // divide by 0x800
  localparam int Q_W      = SUM_W - DIV_SHIFT;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int HEIGHT_LIMIT = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] BORDER_WORD = 16'h8080;

  localparam logic signed [Q_W-1:0] SAT_MAX = 10'sd127;
  localparam logic signed [Q_W-1:0] SAT_MIN = -10'sd128;
  localparam logic signed [Q_W-1:0] OFFSET  = 10'sd128;

  // Control bits that travel with a request down the pipeline.
  typedef struct packed {
    logic pix;       // pixel that updates the line store and window
    logic emit;      // request gives a result
    logic interior;  // result comes from the kernel, not the border word
    logic last;      // final result of the frame
  } item_ctrl_t;

  // Divide by 2048 toward zero, saturate to a byte, add the offset.
  function automatic logic [7:0] scale_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] biased;
    logic signed [Q_W-1:0]   q;
    logic signed [Q_W-1:0]   sat;
    biased = s + (s[SUM_W-1] ? SUM_W'((1 << DIV_SHIFT) - 1) : SUM_W'(0));
    q = Q_W'(biased >>> DIV_SHIFT);
    if (q > SAT_MAX) begin
      sat = SAT_MAX;
    end else if (q < SAT_MIN) begin
      sat = SAT_MIN;
    end else begin
      sat = q;
    end
    return 8'(sat + OFFSET);
  endfunction

endpackage

[rtl/scharr_gradient_packed.sv]
`timescale 1ns / 1ps

// 3x3 Scharr gradient over a raster pixel stream. One request is taken per clock
// while the output is not stalled; each result passes in order through the line store
// read, window shift and line store write, kernel sums, and scale and pack. The two
// line stores share one MAX_WIDTH x 32 memory read and written once per pixel; a
// read of the column written in the same cycle is served from a forwarding register.
// Results lag the input by one row and one column; after the last pixel, drain
// requests flush the pending border results, and the frame's final result carries
// frame_last. A configuration write restarts the frame.
module scharr_gradient_packed #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [scg_pkg::PIX_W-1:0]     in_pixel_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scg_pkg::PIX_W-1:0]     out_packed_gradient,
  output logic                          out_frame_last,
  input  logic                          cfg_we,
  input  logic [scg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scg_pkg::CFG_W-1:0]     cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PW    = scg_pkg::PIX_W;

  logic                 adv, take;
  scg_pkg::item_ctrl_t  a_ctrl, b_ctrl_r, c_ctrl_r, d_ctrl_r;
  logic [COL_W-1:0]     a_col, b_col_r;
  logic [PW-1:0]        b_pix_r;
  logic                 fwd_r;
  logic [scg_pkg::LINE_W-1:0] fwd_data_r, mem_rd, line_rd, line_wr;
  logic                 wr_en;
  logic signed [scg_pkg::SUM_W-1:0] dx_sum, dy_sum;
  logic                 out_valid_r, out_last_r;
  logic [PW-1:0]        out_word_r;

  // whole pipeline moves together; it holds only while a result waits
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign take     = in_valid && adv;

  scg_ctrl #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_W    (COL_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .take     (take),
    .op       (in_opcode),
    .ctrl     (a_ctrl),
    .col      (a_col)
  );

  assign line_rd = fwd_r ? fwd_data_r : mem_rd;
  assign line_wr = {line_rd[PW-1:0], b_pix_r};   // middle moves up, pixel into middle
  assign wr_en   = adv && b_ctrl_r.pix;

  scg_line_mem #(
    .DEPTH(MAX_WIDTH),
    .AW   (COL_W)
  ) u_line_mem (
    .clk    (clk),
    .rd_en  (adv),
    .rd_addr(a_col),
    .rd_data(mem_rd),
    .wr_en  (wr_en),
    .wr_addr(b_col_r),
    .wr_data(line_wr)
  );

  scg_kernel u_kernel (
    .clk     (clk),
    .adv     (adv),
    .shift_en(wr_en),
    .top_px  (line_rd[scg_pkg::LINE_W-1:PW]),
    .mid_px  (line_rd[PW-1:0]),
    .bot_px  (b_pix_r),
    .dx_sum  (dx_sum),
    .dy_sum  (dy_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctrl_r    <= '0;
      c_ctrl_r    <= '0;
      d_ctrl_r    <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_ctrl_r    <= take ? a_ctrl : '0;
      c_ctrl_r    <= b_ctrl_r;
      d_ctrl_r    <= c_ctrl_r;
      // same column written this edge: memory returns stale data
      fwd_r       <= b_ctrl_r.pix && (b_col_r == a_col);
      out_valid_r <= d_ctrl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pix_r    <= in_pixel_value;
      b_col_r    <= a_col;
      fwd_data_r <= line_wr;
      out_last_r <= d_ctrl_r.last;
      out_word_r <= d_ctrl_r.interior ?
                    {scg_pkg::scale_sat(dy_sum), scg_pkg::scale_sat(dx_sum)} :
                    scg_pkg::BORDER_WORD;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_packed_gradient = out_word_r;
  assign out_frame_last      = out_last_r;

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while output register free");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (take && a_ctrl.last) |-> a_ctrl.emit)
    else $error("frame end flagged on a request without result");

  a_interior_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    b_ctrl_r.interior |-> (b_ctrl_r.pix && b_ctrl_r.emit))
    else $error("kernel result on a non-pixel request");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(d_ctrl_r) && $stable(c_ctrl_r) && $stable(b_ctrl_r)))
    else $error("pipeline moved while output stalled");

endmodule

[rtl/scg_line_mem.sv]
`timescale 1ns / 1ps

module scg_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [scg_pkg::LINE_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [scg_pkg::LINE_W-1:0] wr_data
);

  logic [scg_pkg::LINE_W-1:0] mem [DEPTH];
  logic [scg_pkg::LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/scg_ctrl.sv]
`timescale 1ns / 1ps

module scg_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scg_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          take,
  input  logic                          op,
  output scg_pkg::item_ctrl_t           ctrl,
  output logic [COL_W-1:0]              col
);

  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = scg_pkg::HEIGHT_W;
  localparam int RW    = scg_pkg::ROW_W;
  localparam int TOT_W = $clog2(MAX_WIDTH) + RW;
  localparam int PW    = EW + HW;
  localparam int RST_W = (scg_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : scg_pkg::WIDTH_RESET;
  localparam int RST_TOT_M1 = RST_W * scg_pkg::HEIGHT_RESET - 1;

  function automatic logic [EW-1:0] eff_width(input logic [scg_pkg::WIDTH_W-1:0] w);
    logic [EW-1:0] r;
    if (w == '0) begin
      r = EW'(1);
    end else if (int'(w) > MAX_WIDTH) begin
      r = EW'(MAX_WIDTH);
    end else begin
      r = EW'(w);
    end
    return r;
  endfunction

  function automatic logic [HW-1:0] eff_height(input logic [HW-1:0] h);
    logic [HW-1:0] r;
    if (h == '0) begin
      r = HW'(1);
    end else if (int'(h) > scg_pkg::HEIGHT_LIMIT) begin
      r = HW'(scg_pkg::HEIGHT_LIMIT);
    end else begin
      r = h;
    end
    return r;
  endfunction

  logic [EW-1:0]    w_eff_r;
  logic [HW-1:0]    h_eff_r;
  logic [TOT_W-1:0] total_m1_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [TOT_W-1:0] emitted_r, emitted_nxt;
  logic             done_r, done_nxt;

  logic [EW-1:0]    w_cfg, w_prod;
  logic [HW-1:0]    h_cfg, h_prod;
  logic [PW-1:0]    product;
  logic             pix_op, drain_op, ready, interior, emit, last;
  logic             last_col, last_row;

  always_comb begin
    w_cfg = eff_width(cfg_data[scg_pkg::WIDTH_W-1:0]);
    h_cfg = eff_height(cfg_data[HW-1:0]);
    w_prod = (cfg_index == scg_pkg::CFG_IMAGE_WIDTH) ? w_cfg : w_eff_r;
    h_prod = (cfg_index == scg_pkg::CFG_IMAGE_HEIGHT) ? h_cfg : h_eff_r;
    product = PW'(w_prod) * PW'(h_prod);
  end

  always_comb begin
    pix_op   = (op == scg_pkg::OP_PIXEL) && !done_r;
    drain_op = (op == scg_pkg::OP_DRAIN) && done_r;
    // raster index >= width + 1, without the multiply
    ready    = (row_r >= RW'(2)) || ((row_r != '0) && (col_r != '0));
    interior = pix_op && (row_r >= RW'(2)) && (col_r >= COL_W'(2));
    emit     = (pix_op && ready) || drain_op;
    last     = emit && (emitted_r == total_m1_r);
    last_col = (EW'(col_r) + EW'(1)) == w_eff_r;
    last_row = (HW'(row_r) + HW'(1)) == h_eff_r;

    col_nxt     = col_r;
    row_nxt     = row_r;
    emitted_nxt = emitted_r;
    done_nxt    = done_r;
    if (take) begin
      if (pix_op) begin
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
          if (last_row) begin
            done_nxt = 1'b1;
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      if (last) begin
        col_nxt     = '0;
        row_nxt     = '0;
        emitted_nxt = '0;
        done_nxt    = 1'b0;
      end else if (emit) begin
        emitted_nxt = emitted_r + TOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r    <= EW'(RST_W);
      h_eff_r    <= HW'(scg_pkg::HEIGHT_RESET);
      total_m1_r <= TOT_W'(RST_TOT_M1);
      col_r      <= '0;
      row_r      <= '0;
      emitted_r  <= '0;
      done_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scg_pkg::CFG_IMAGE_WIDTH:  w_eff_r <= w_cfg;
        scg_pkg::CFG_IMAGE_HEIGHT: h_eff_r <= h_cfg;
        default: ;
      endcase
      total_m1_r <= TOT_W'(product - PW'(1));
      col_r      <= '0;
      row_r      <= '0;
      emitted_r  <= '0;
      done_r     <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      emitted_r <= emitted_nxt;
      done_r    <= done_nxt;
    end
  end

  always_comb begin
    ctrl.pix      = pix_op;
    ctrl.emit     = emit;
    ctrl.interior = interior;
    ctrl.last     = last;
  end

  assign col = col_r;

endmodule

[rtl/scg_kernel.sv]
`timescale 1ns / 1ps

module scg_kernel (
  input  logic                              clk,
  input  logic                              adv,
  input  logic                              shift_en,
  input  logic [scg_pkg::PIX_W-1:0]         top_px,
  input  logic [scg_pkg::PIX_W-1:0]         mid_px,
  input  logic [scg_pkg::PIX_W-1:0]         bot_px,
  output logic signed [scg_pkg::SUM_W-1:0]  dx_sum,
  output logic signed [scg_pkg::SUM_W-1:0]  dy_sum
);

  localparam int SW = scg_pkg::SUM_W;
  localparam int DW = scg_pkg::PIX_W + 1;

  // [row top..bottom][col oldest..newest]
  logic [scg_pkg::PIX_W-1:0] win_r [3][3];
  logic signed [SW-1:0] dx_sum_r, dy_sum_r;
  logic signed [DW-1:0] dx0, dx1, dx2, dy0, dy1, dy2;
  logic signed [SW-1:0] dx_nxt, dy_nxt;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= top_px;
      win_r[1][2] <= mid_px;
      win_r[2][2] <= bot_px;
    end
  end

  always_comb begin
    dx0 = $signed({1'b0, win_r[0][0]}) - $signed({1'b0, win_r[0][2]});
    dx1 = $signed({1'b0, win_r[1][0]}) - $signed({1'b0, win_r[1][2]});
    dx2 = $signed({1'b0, win_r[2][0]}) - $signed({1'b0, win_r[2][2]});
    dy0 = $signed({1'b0, win_r[0][0]}) - $signed({1'b0, win_r[2][0]});
    dy1 = $signed({1'b0, win_r[0][1]}) - $signed({1'b0, win_r[2][1]});
    dy2 = $signed({1'b0, win_r[0][2]}) - $signed({1'b0, win_r[2][2]});
    dx_nxt = SW'(dx0) * SW'(3) + SW'(dx1) * SW'(10) + SW'(dx2) * SW'(3);
    dy_nxt = SW'(dy0) * SW'(3) + SW'(dy1) * SW'(10) + SW'(dy2) * SW'(3);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_sum_r <= dx_nxt;
      dy_sum_r <= dy_nxt;
    end
  end

  assign dx_sum = dx_sum_r;
  assign dy_sum = dy_sum_r;

endmodule

[dv/tb_scharr_gradient_packed.sv]
`timescale 1ns / 1ps

module tb_scharr_gradient_packed;

  localparam int MAX_W       = 1024;
  localparam int SETTLE_CYC  = 8;
  localparam int TOTAL_ITEMS = 1850;

  typedef struct packed {
    logic                      op;
    logic [scg_pkg::PIX_W-1:0] pix;
  } pixel_req_t;

  typedef struct packed {
    logic [scg_pkg::PIX_W-1:0] grad;
    logic                      last;
  } grad_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_opcode = scg_pkg::OP_PIXEL;
  logic [scg_pkg::PIX_W-1:0]     in_pixel_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [scg_pkg::PIX_W-1:0]     out_packed_gradient;
  logic                          out_frame_last;
  logic                          cfg_we = 1'b0;
  logic [scg_pkg::CFG_IDX_W-1:0] cfg_index = scg_pkg::CFG_IMAGE_WIDTH;
  logic [scg_pkg::CFG_W-1:0]     cfg_data = '0;

  scharr_gradient_packed #(.MAX_WIDTH(MAX_W)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_pixel_value      (in_pixel_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_packed_gradient (out_packed_gradient),
    .out_frame_last      (out_frame_last),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  pixel_req_t   pixel_req_q[$];
  grad_result_t grad_expected_q[$];
  int unsigned  items_queued = 0;
  int unsigned  items_accepted = 0;
  int unsigned  mismatches = 0;

  // ---------------------------------------------------------------------------
  // Gradient predictor state
  // ---------------------------------------------------------------------------
  logic [scg_pkg::WIDTH_W-1:0]  width_reg = 11'(scg_pkg::WIDTH_RESET);
  logic [scg_pkg::HEIGHT_W-1:0] height_reg = 13'(scg_pkg::HEIGHT_RESET);
  logic [scg_pkg::PIX_W-1:0]    line_above [MAX_W];
  logic [scg_pkg::PIX_W-1:0]    line_mid [MAX_W];
  logic [scg_pkg::PIX_W-1:0]    kern_win [3][3];  // [top..bottom][oldest..newest]
  int unsigned                  col_pos = 0;
  int unsigned                  row_pos = 0;
  int unsigned                  results_out = 0;
  logic                         frame_done = 1'b0;

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      line_above[i] = '0;
      line_mid[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kern_win[i][j] = '0;
      end
    end
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > scg_pkg::HEIGHT_LIMIT) return scg_pkg::HEIGHT_LIMIT;
    return 32'(height_reg);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    results_out = 0;
    frame_done = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kern_win[i][j] = '0;
      end
    end
  endfunction

  function automatic void apply_cfg(logic [scg_pkg::CFG_IDX_W-1:0] idx,
                                    logic [scg_pkg::CFG_W-1:0] val);
    if (idx == scg_pkg::CFG_IMAGE_WIDTH) begin
      width_reg = val[scg_pkg::WIDTH_W-1:0];
    end else begin
      height_reg = val[scg_pkg::HEIGHT_W-1:0];
    end
    restart_frame();
  endfunction

  function automatic logic [7:0] sat_byte(int s);
    int q;
    q = s / 2048;  // truncates toward zero
    if (q > 127) q = 127;
    if (q < -128) q = -128;
    return 8'(q + 128);
  endfunction

  function automatic logic [scg_pkg::PIX_W-1:0] scharr_word();
    int dx;
    int dy;
    dx = 3 * (int'(kern_win[0][0]) - int'(kern_win[0][2]))
       + 10 * (int'(kern_win[1][0]) - int'(kern_win[1][2]))
       + 3 * (int'(kern_win[2][0]) - int'(kern_win[2][2]));
    dy = 3 * (int'(kern_win[0][0]) - int'(kern_win[2][0]))
       + 10 * (int'(kern_win[0][1]) - int'(kern_win[2][1]))
       + 3 * (int'(kern_win[0][2]) - int'(kern_win[2][2]));
    return {sat_byte(dy), sat_byte(dx)};
  endfunction

  function automatic void post_result(logic [scg_pkg::PIX_W-1:0] word);
    logic last;
    last = (results_out + 1) >= eff_width() * eff_height();
    grad_expected_q.push_back('{grad: word, last: last});
    if (last) begin
      restart_frame();
    end else begin
      results_out++;
    end
  endfunction

  function automatic void predict_gradient(logic op, logic [scg_pkg::PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic ready;
    logic interior;
    logic [scg_pkg::PIX_W-1:0] word;
    w = eff_width();
    h = eff_height();
    if (op == scg_pkg::OP_DRAIN) begin
      // drain before the frame is complete gives nothing
      if (frame_done) post_result(scg_pkg::BORDER_WORD);
      return;
    end
    if (frame_done) return;  // excess pixel
    c = col_pos;
    r = row_pos;
    for (int i = 0; i < 3; i++) begin
      kern_win[i][0] = kern_win[i][1];
      kern_win[i][1] = kern_win[i][2];
    end
    kern_win[0][2] = line_above[c];
    kern_win[1][2] = line_mid[c];
    kern_win[2][2] = pix;
    line_above[c] = line_mid[c];
    line_mid[c] = pix;
    ready = (r * w + c) >= (w + 1);
    interior = (c >= 2) && (r >= 2);
    word = interior ? scharr_word() : scg_pkg::BORDER_WORD;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) frame_done = 1'b1;
    end
    if (ready) post_result(word);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  pixel_req_t  next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_gradient(in_opcode, in_pixel_value);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_req_q.size() != 0) begin
          next_req = pixel_req_q.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_req.op;
          in_pixel_value <= next_req.pix;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  int unsigned stall_run = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_run == 0) begin
            out_stall <= ~out_stall;
            stall_run = $urandom_range(1, 12);
          end else begin
            stall_run--;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  grad_result_t head_res;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (grad_expected_q.size() == 0) begin
        $error("unexpected result: packed_gradient %h frame_last %b",
               out_packed_gradient, out_frame_last);
        mismatches++;
      end else begin
        head_res = grad_expected_q.pop_front();
        if (out_packed_gradient !== head_res.grad) begin
          $error("packed_gradient: expected %h, got %h", head_res.grad, out_packed_gradient);
          mismatches++;
        end
        if (out_frame_last !== head_res.last) begin
          $error("frame_last: expected %b, got %b", head_res.last, out_frame_last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(logic op, logic [scg_pkg::PIX_W-1:0] pix);
    pixel_req_q.push_back('{op: op, pix: pix});
    items_queued++;
  endtask

  // wait until every request is taken and every result is back
  task automatic settle();
    while (items_accepted != items_queued || grad_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [scg_pkg::CFG_IDX_W-1:0] idx,
                           logic [scg_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_cfg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [scg_pkg::PIX_W-1:0] frame_pixel(int pat, int c, int r, int sx,
                                                            int sy, int base);
    case (pat)
      0: return 16'($urandom);
      1: return 16'(base + c * sx + r * sy + int'($urandom_range(0, 255)));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic run_frame(int unsigned w, int unsigned h);
    int pat;
    int sx;
    int sy;
    int base;
    int unsigned drains;
    pat = $urandom_range(0, 3);
    sx = int'($urandom_range(0, 12000)) - 6000;
    sy = int'($urandom_range(0, 12000)) - 6000;
    base = $urandom;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(0, 39) == 0) push_req(scg_pkg::OP_DRAIN, 16'($urandom));
        push_req(scg_pkg::OP_PIXEL, frame_pixel(pat, c, r, sx, sy, base));
      end
    end
    if ($urandom_range(0, 3) == 0) push_req(scg_pkg::OP_PIXEL, 16'($urandom));
    drains = (w * h < w + 1) ? w * h : w + 1;
    for (int i = 0; i < drains; i++) push_req(scg_pkg::OP_DRAIN, 16'($urandom));
    if ($urandom_range(0, 9) == 0) push_req(scg_pkg::OP_DRAIN, 16'($urandom));
  endtask

  // frame too large to finish: feed a little past the first row; a later configuration write restarts it
  task automatic run_partial(int unsigned w, int unsigned h);
    int unsigned n;
    n = w + 1 + $urandom_range(1, 60);
    if (n > w * h) n = w * h;
    for (int i = 0; i < n; i++) push_req(scg_pkg::OP_PIXEL, 16'($urandom));
  endtask

  task automatic run_phase();
    int sel;
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    logic [scg_pkg::WIDTH_W-1:0] wv;
    logic [scg_pkg::HEIGHT_W-1:0] hv;
    sel = $urandom_range(0, 3);
    case ($urandom_range(0, 14))
      0: wv = '0;
      1: wv = 11'd1;
      default: wv = 11'($urandom_range(2, 14));
    endcase
    case ($urandom_range(0, 11))
      0: hv = '0;
      1: hv = '1;
      2: hv = 13'd1;
      default: hv = 13'($urandom_range(2, 7));
    endcase
    if (sel != 1) write_reg(scg_pkg::CFG_IMAGE_WIDTH, {2'($urandom), wv});
    if (sel != 0) write_reg(scg_pkg::CFG_IMAGE_HEIGHT, hv);
    if (sel == 3) write_reg(scg_pkg::CFG_IMAGE_WIDTH, {2'($urandom), wv});
    w = eff_width();
    h = eff_height();
    if (w * h > 300) begin
      run_partial(w, h);
    end else begin
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        run_frame(w, h);
        if ($urandom_range(0, 3) == 0) settle();
      end
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame: saturated dx and dy at the single interior pixel, plus
    // early drain, excess pixel and a drain that opens the next frame
    write_reg(scg_pkg::CFG_IMAGE_WIDTH, 13'd3);
    write_reg(scg_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    push_req(scg_pkg::OP_DRAIN, 16'hFFFF);
    push_req(scg_pkg::OP_PIXEL, 16'hFFFF);
    push_req(scg_pkg::OP_PIXEL, 16'h0000);
    push_req(scg_pkg::OP_PIXEL, 16'h0000);
    push_req(scg_pkg::OP_PIXEL, 16'hFFFF);
    push_req(scg_pkg::OP_PIXEL, 16'h0000);
    push_req(scg_pkg::OP_PIXEL, 16'h0000);
    push_req(scg_pkg::OP_PIXEL, 16'hFFFF);
    push_req(scg_pkg::OP_PIXEL, 16'hFFFF);
    push_req(scg_pkg::OP_PIXEL, 16'hFFFF);
    push_req(scg_pkg::OP_PIXEL, 16'h1234);
    repeat (4) push_req(scg_pkg::OP_DRAIN, 16'h0000);
    push_req(scg_pkg::OP_DRAIN, 16'h0000);
    settle();

    // widest and tallest settings, both clamped
    write_reg(scg_pkg::CFG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(scg_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    run_partial(eff_width(), eff_height());
    settle();

    while (items_queued < TOTAL_ITEMS) run_phase();
    settle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
